/* sv/onewire_temp_sensor_master_defines.svh */
// Assertion helpers shared by the bus master RTL.
`ifndef ONEWIRE_TEMP_SENSOR_MASTER_DEFINES_SVH
`define ONEWIRE_TEMP_SENSOR_MASTER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OWTS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OWTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/owts_pkg.sv */
`timescale 1ns / 1ps
package owts_pkg;

   localparam int NUM_LINES = 3;
   localparam int CNT_W     = 10;
   localparam int PROG_LEN  = 10;

   // Start codes carried in the mode field
   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_TEMP  = 3'd1;
   localparam logic [2:0] MODE_RESET = 3'd2;
   localparam logic [2:0] MODE_WRITE = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;

   // Timing register indexes
   localparam logic [2:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [2:0] CSR_PRESENCE_WAIT = 3'd1;
   localparam logic [2:0] CSR_RESET_RECOV   = 3'd2;
   localparam logic [2:0] CSR_SLOT_LOW      = 3'd3;
   localparam logic [2:0] CSR_WRITE_SLOT    = 3'd4;
   localparam logic [2:0] CSR_READ_SAMPLE   = 3'd5;
   localparam logic [2:0] CSR_READ_TAIL     = 3'd6;

   localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
   localparam logic [7:0] CMD_CONVERT   = 8'h44;
   localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
   localparam logic [13:0] FRAC_SCALE   = 14'd625;

   typedef enum logic [8:0] {
      PH_IDLE     = 9'b0_0000_0001,
      PH_RST_LOW  = 9'b0_0000_0010,
      PH_RST_WAIT = 9'b0_0000_0100,
      PH_RST_REC  = 9'b0_0000_1000,
      PH_WSLOT    = 9'b0_0001_0000,
      PH_WHOLD    = 9'b0_0010_0000,
      PH_RSLOT    = 9'b0_0100_0000,
      PH_RSAMPLE  = 9'b0_1000_0000,
      PH_RTAIL    = 9'b1_0000_0000
   } phase_type;

   typedef enum logic [1:0] {
      PR_RST  = 2'd0,
      PR_WR   = 2'd1,
      PR_RD   = 2'd2,
      PR_POLL = 2'd3
   } prim_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [1:0] device_number;
      logic [7:0] data_byte;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic              drive_low;
      logic [1:0]        line_select;
      logic              busy_res;
      logic              done_res;
      logic              presence_missing;
      logic [7:0]        read_data;
      logic signed [7:0] temp_integer;
      logic [13:0]       temp_fraction;
   } rsp_type;

   // Primitive sequence of the temperature read
   function automatic prim_type prog_kind(input logic [3:0] step);
      prim_type kind;
      begin
         case (step)
            4'd0:    kind = PR_RST;
            4'd1:    kind = PR_WR;
            4'd2:    kind = PR_WR;
            4'd3:    kind = PR_POLL;
            4'd4:    kind = PR_RST;
            4'd5:    kind = PR_WR;
            4'd6:    kind = PR_WR;
            4'd7:    kind = PR_RD;
            4'd8:    kind = PR_RD;
            default: kind = PR_RST;
         endcase
         return kind;
      end
   endfunction

   function automatic logic [7:0] prog_byte(input logic [3:0] step);
      logic [7:0] b;
      begin
         case (step)
            4'd1:    b = CMD_SKIP_ROM;
            4'd2:    b = CMD_CONVERT;
            4'd5:    b = CMD_SKIP_ROM;
            4'd6:    b = CMD_READ_PAD;
            default: b = 8'h00;
         endcase
         return b;
      end
   endfunction

   // Primitive that the current operation runs at this step
   function automatic prim_type cur_prim(input logic [2:0] op, input logic [3:0] step);
      prim_type p;
      begin
         case (op)
            MODE_TEMP:  p = prog_kind(step);
            MODE_WRITE: p = PR_WR;
            MODE_READ:  p = PR_RD;
            default:    p = PR_RST;
         endcase
         return p;
      end
   endfunction

endpackage

/* sv/onewire_temp_sensor_master.sv */
`timescale 1ns / 1ps
// A response beat is registered: it leaves the output register in the cycle after its request beat.
// Throughput: 1 request beat per cycle; the only stall comes from a held response beat.
// Each request beat is one bus tick; a full temperature read spans thousands of beats.
// Reset (synchronous, active high): go idle, clear the sequencer and results, select
// line 0 and load the default bus timings. No clearing pass is needed.
`include "onewire_temp_sensor_master_defines.svh"

module onewire_temp_sensor_master (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  owts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output owts_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [9:0]       csr_wdata
);

   // Timing registers
   logic [9:0] reset_low_ff;
   logic [7:0] presence_wait_ff;
   logic [9:0] reset_recov_ff;
   logic [3:0] slot_low_ff;
   logic [7:0] write_slot_ff;
   logic [5:0] read_sample_ff;
   logic [7:0] read_tail_ff;

   // Sequencer state
   owts_pkg::phase_type        phase_ff, phase_in;
   logic [2:0]                 op_ff, op_in;
   logic [3:0]                 step_ff, step_in;
   logic [owts_pkg::CNT_W-1:0] tick_ff, tick_in;
   logic [2:0]                 bit_ff, bit_in;
   logic [7:0]                 shift_ff, shift_in;
   logic [7:0]                 scratch_ff, scratch_in;
   logic [1:0]                 sel_ff, sel_in;
   logic                       presence_ff, presence_in;
   logic [7:0]                 last_read_ff, last_read_in;
   logic [7:0]                 held_int_ff, held_int_in;
   logic [13:0]                held_frac_ff, held_frac_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   owts_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic [owts_pkg::CNT_W:0] len_cur;
   logic                     hit;
   logic                     start_prim;
   logic                     finish_prim;
   logic                     done;
   owts_pkg::prim_type       next_prim;

   // Take a new tick whenever the output register is free or drains this cycle.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Length of the running phase; a zero register still lasts one tick.
   always_comb begin
      case (phase_ff)
         owts_pkg::PH_RST_LOW:  len_cur = (owts_pkg::CNT_W+1)'(reset_low_ff);
         owts_pkg::PH_RST_WAIT: len_cur = (owts_pkg::CNT_W+1)'(presence_wait_ff);
         owts_pkg::PH_RST_REC:  len_cur = (owts_pkg::CNT_W+1)'(reset_recov_ff);
         owts_pkg::PH_WSLOT:    len_cur = (owts_pkg::CNT_W+1)'(slot_low_ff);
         owts_pkg::PH_WHOLD:    len_cur = (owts_pkg::CNT_W+1)'(write_slot_ff);
         owts_pkg::PH_RSLOT:    len_cur = (owts_pkg::CNT_W+1)'(slot_low_ff);
         owts_pkg::PH_RSAMPLE:  len_cur = (owts_pkg::CNT_W+1)'(read_sample_ff);
         owts_pkg::PH_RTAIL:    len_cur = (owts_pkg::CNT_W+1)'(read_tail_ff);
         default:               len_cur = '0;
      endcase
   end

   assign hit = ((owts_pkg::CNT_W+1)'(tick_ff) + 1'b1) >= len_cur;

   // One tick of the bus sequencer.
   always_comb begin
      phase_in     = phase_ff;
      op_in        = op_ff;
      step_in      = step_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      scratch_in   = scratch_ff;
      sel_in       = sel_ff;
      presence_in  = presence_ff;
      last_read_in = last_read_ff;
      held_int_in  = held_int_ff;
      held_frac_in = held_frac_ff;
      start_prim   = 1'b0;
      finish_prim  = 1'b0;
      done         = 1'b0;
      next_prim    = owts_pkg::PR_RST;

      // Advance the phase timer; wrap to zero on the last tick of the phase.
      if (phase_ff != owts_pkg::PH_IDLE) begin
         tick_in = hit ? '0 : owts_pkg::CNT_W'(tick_ff + 1'b1);
      end

      case (phase_ff)
         owts_pkg::PH_IDLE: begin
            if (req_data.mode >= owts_pkg::MODE_TEMP && req_data.mode <= owts_pkg::MODE_READ) begin
               if (req_data.device_number != 2'd0 &&
                   int'(req_data.device_number) <= owts_pkg::NUM_LINES) begin
                  sel_in = req_data.device_number - 2'd1;
               end
               op_in   = req_data.mode;
               step_in = '0;
               if (req_data.mode == owts_pkg::MODE_WRITE) begin
                  shift_in = req_data.data_byte;
               end
               start_prim = 1'b1;
            end
         end
         owts_pkg::PH_RST_LOW: begin
            if (hit) begin
               phase_in = owts_pkg::PH_RST_WAIT;
            end
         end
         owts_pkg::PH_RST_WAIT: begin
            if (hit) begin
               presence_in = req_data.line_level;
               phase_in    = owts_pkg::PH_RST_REC;
            end
         end
         owts_pkg::PH_RST_REC: begin
            if (hit) begin
               finish_prim = 1'b1;
            end
         end
         owts_pkg::PH_WSLOT: begin
            if (hit) begin
               phase_in = owts_pkg::PH_WHOLD;
            end
         end
         owts_pkg::PH_WHOLD: begin
            if (hit) begin
               shift_in = {1'b0, shift_ff[7:1]};
               if (bit_ff == 3'd7) begin
                  finish_prim = 1'b1;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = owts_pkg::PH_WSLOT;
               end
            end
         end
         owts_pkg::PH_RSLOT: begin
            if (hit) begin
               phase_in = owts_pkg::PH_RSAMPLE;
            end
         end
         owts_pkg::PH_RSAMPLE: begin
            if (hit) begin
               shift_in = {req_data.line_level, shift_ff[7:1]};
               phase_in = owts_pkg::PH_RTAIL;
            end
         end
         owts_pkg::PH_RTAIL: begin
            if (hit) begin
               // The conversion poll repeats single slots until a 1 comes back.
               if (owts_pkg::cur_prim(op_ff, step_ff) == owts_pkg::PR_POLL) begin
                  if (shift_ff[7]) begin
                     finish_prim = 1'b1;
                  end else begin
                     phase_in = owts_pkg::PH_RSLOT;
                  end
               end else if (bit_ff == 3'd7) begin
                  finish_prim = 1'b1;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = owts_pkg::PH_RSLOT;
               end
            end
         end
         default: begin
            phase_in = owts_pkg::PH_IDLE;
         end
      endcase

      // Close the current primitive: finish the operation or step the program.
      if (finish_prim) begin
         if (op_ff != owts_pkg::MODE_TEMP) begin
            if (op_ff == owts_pkg::MODE_READ) begin
               last_read_in = shift_in;
            end
            phase_in = owts_pkg::PH_IDLE;
            done     = 1'b1;
         end else begin
            if (step_ff == 4'd7) begin
               scratch_in = shift_in;
            end
            if (int'(step_ff) >= owts_pkg::PROG_LEN - 1) begin
               // MSB low nibble and LSB high nibble form the signed whole degrees.
               held_int_in  = {shift_ff[3:0], scratch_ff[7:4]};
               held_frac_in = owts_pkg::FRAC_SCALE * {10'd0, scratch_ff[3:0]};
               phase_in     = owts_pkg::PH_IDLE;
               step_in      = '0;
               done         = 1'b1;
            end else begin
               step_in    = step_ff + 4'd1;
               start_prim = 1'b1;
            end
         end
      end

      // Open the next primitive at the first phase of its kind.
      if (start_prim) begin
         tick_in   = '0;
         bit_in    = '0;
         next_prim = owts_pkg::cur_prim(op_in, step_in);
         case (next_prim)
            owts_pkg::PR_RST: begin
               phase_in = owts_pkg::PH_RST_LOW;
            end
            owts_pkg::PR_WR: begin
               if (op_in == owts_pkg::MODE_TEMP && int'(step_in) < owts_pkg::PROG_LEN) begin
                  shift_in = owts_pkg::prog_byte(step_in);
               end
               phase_in = owts_pkg::PH_WSLOT;
            end
            default: begin
               phase_in = owts_pkg::PH_RSLOT;
            end
         endcase
      end
   end

   // Response beat describes the bus after this tick.
   always_comb begin
      rsp_data_in.drive_low = (phase_in == owts_pkg::PH_RST_LOW) ||
                              (phase_in == owts_pkg::PH_WSLOT) ||
                              (phase_in == owts_pkg::PH_RSLOT) ||
                              (phase_in == owts_pkg::PH_WHOLD && !shift_in[0]);
      rsp_data_in.line_select      = sel_in;
      rsp_data_in.busy_res         = (phase_in != owts_pkg::PH_IDLE);
      rsp_data_in.done_res         = done;
      rsp_data_in.presence_missing = presence_in;
      rsp_data_in.read_data        = last_read_in;
      rsp_data_in.temp_integer     = held_int_in;
      rsp_data_in.temp_fraction    = held_frac_in;
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Timing registers: take a write at any time, mask to the register width.
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff     <= 10'd480;
         presence_wait_ff <= 8'd60;
         reset_recov_ff   <= 10'd420;
         slot_low_ff      <= 4'd1;
         write_slot_ff    <= 8'd60;
         read_sample_ff   <= 6'd14;
         read_tail_ff     <= 8'd45;
      end else if (csr_wr_en) begin
         case (csr_index)
            owts_pkg::CSR_RESET_LOW:     reset_low_ff     <= csr_wdata;
            owts_pkg::CSR_PRESENCE_WAIT: presence_wait_ff <= csr_wdata[7:0];
            owts_pkg::CSR_RESET_RECOV:   reset_recov_ff   <= csr_wdata;
            owts_pkg::CSR_SLOT_LOW:      slot_low_ff      <= csr_wdata[3:0];
            owts_pkg::CSR_WRITE_SLOT:    write_slot_ff    <= csr_wdata[7:0];
            owts_pkg::CSR_READ_SAMPLE:   read_sample_ff   <= csr_wdata[5:0];
            owts_pkg::CSR_READ_TAIL:     read_tail_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Sequencer: advance only on an accepted tick beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= owts_pkg::PH_IDLE;
         op_ff        <= owts_pkg::MODE_TICK;
         step_ff      <= '0;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         scratch_ff   <= '0;
         sel_ff       <= '0;
         presence_ff  <= 1'b0;
         last_read_ff <= '0;
         held_int_ff  <= '0;
         held_frac_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         scratch_ff   <= scratch_in;
         sel_ff       <= sel_in;
         presence_ff  <= presence_in;
         last_read_ff <= last_read_in;
         held_int_ff  <= held_int_in;
         held_frac_ff <= held_frac_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload while stalled; load it on every accepted beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `OWTS_ASSERT_SAME(a_done_not_busy, rsp_valid_ff && rsp_data_ff.done_res,
      !rsp_data_ff.busy_res, "done beat reports busy")
   `OWTS_ASSERT_SAME(a_busy_tracks_phase, rsp_valid_ff,
      rsp_data_ff.busy_res == (phase_ff != owts_pkg::PH_IDLE), "busy disagrees with phase")
   `OWTS_ASSERT_SAME(a_drive_needs_busy, rsp_valid_ff && rsp_data_ff.drive_low,
      rsp_data_ff.busy_res, "line driven low while idle")
   `OWTS_ASSERT_NEXT(a_start_leaves_idle,
      accept && phase_ff == owts_pkg::PH_IDLE && req_data.mode >= owts_pkg::MODE_TEMP &&
      req_data.mode <= owts_pkg::MODE_READ,
      phase_ff != owts_pkg::PH_IDLE, "start request did not leave idle")
   `OWTS_ASSERT_SAME(a_idle_timer_clear, phase_ff == owts_pkg::PH_IDLE,
      tick_ff == '0, "phase timer running while idle")

endmodule
